>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the stack block.
// Depends on nothing; a file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lss_pkg.sv
// Package of the LIFO stack with search: sizes, operation and status codes,
// and the result record. Depends on nothing.
package lss_pkg;

   localparam int DEPTH       = 16;
   localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEVEL_W     = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int LEVEL_OUT_W = 5;
   localparam int LVL_EXT_W   = LEVEL_W + LEVEL_OUT_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      status_type                status;
      logic                      found;
      logic [LEVEL_OUT_W-1:0]    level;
      logic                      is_empty;
      logic                      is_full;
   } res_type;

endpackage

>>> hdl/lss_chan_if.sv
// Valid/ready channel interfaces for the request and response sides of the
// stack block. Depends on lss_pkg.
interface lss_req_if import lss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface lss_rsp_if import lss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   logic [STATUS_W-1:0]       status;
   logic                      found;
   logic [LEVEL_OUT_W-1:0]    level;
   logic                      is_empty;
   logic                      is_full;

   modport source (output valid, output read_value, output status, output found,
                   output level, output is_empty, output is_full, input ready);
   modport sink   (input valid, input read_value, input status, input found,
                   input level, input is_empty, input is_full, output ready);
endinterface

>>> hdl/lss_ram.sv
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Depends on nothing.
module lss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> hdl/lifo_stack_with_search.sv
// LIFO stack of signed 32-bit words with push, pop, peek and search.
// Depends on lss_pkg, lss_req_if, lss_rsp_if and lss_ram.
//
// Usage: each request on req_chan carries an operation and a value. Every
// request produces exactly one response on rsp_chan with the word read, a
// status code, a found flag, the level after the operation and the empty
// and full flags. Both channels use valid/ready; a transfer happens on a
// rising clock edge with valid and ready both high.
// Sequencing: a push, and a pop or peek on an empty stack, finish in the
// cycle the request is taken and the response goes to the response register
// (or to the hold register while the receiver stalls). A pop or peek of a
// held word reads the top entry and answers from state S_READ. A search reads
// the held entries one per cycle from the bottom and stops at the first match
// or at the top entry. The entry memory has a single read port, and one
// request is in progress at a time.
// Reset (synchronous, active high) empties the stack and drops any pending
// response; the entry memory itself is not cleared.
// A stalled receiver does not block intake: the response register holds the
// waiting response while the next request is taken and worked on, and a
// second finished response parks in a hold register until the first leaves.
module lifo_stack_with_search import lss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lss_req_if.sink   req_chan,
   lss_rsp_if.source rsp_chan
);

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_SEARCH = 4'b0100,
      S_HOLD   = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [LEVEL_W-1:0]        level_ff, level_in;
   logic [ADDR_W-1:0]         chk_ff, chk_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   res_type                   hold_ff, hold_in;
   res_type                   out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic [VALUE_W-1:0]        rd_data;

   logic                      done;
   logic                      slot_free;
   logic                      is_empty_now;
   logic                      is_full_now;
   logic [ADDR_W-1:0]         top_addr;
   logic [LVL_EXT_W-1:0]      lvl_wide;
   res_type                   res;

   // Entry memory: entry i holds the (i+1)-th word from the bottom.
   lss_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free    = !out_valid_ff || rsp_chan.ready;
   assign is_empty_now = (level_ff == '0);
   assign is_full_now  = (level_ff == LEVEL_W'(DEPTH));
   // Index of the top word; only used when the stack is not empty.
   assign top_addr     = ADDR_W'(level_ff - LEVEL_W'(1));

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      chk_in       = chk_ff;
      key_in       = key_ff;
      hold_in      = hold_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = level_ff[ADDR_W-1:0];
      wr_data      = req_chan.value;
      rd_addr      = ADDR_W'(chk_ff + ADDR_W'(1));
      done         = 1'b0;
      res          = '0;
      res.status   = STAT_OK;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               key_in = req_chan.value;
               case (op_type'(req_chan.op))
                  OP_PUSH: begin
                     done = 1'b1;
                     if (is_full_now) begin
                        res.status = STAT_OVER;
                     end else begin
                        wr_en    = 1'b1;
                        level_in = level_ff + LEVEL_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (is_empty_now) begin
                        res.status = STAT_UNDER;
                        done       = 1'b1;
                     end else begin
                        rd_addr  = top_addr;
                        level_in = level_ff - LEVEL_W'(1);
                        state_in = S_READ;
                     end
                  end
                  OP_PEEK: begin
                     if (is_empty_now) begin
                        res.status = STAT_UNDER;
                        done       = 1'b1;
                     end else begin
                        rd_addr  = top_addr;
                        state_in = S_READ;
                     end
                  end
                  OP_SEARCH: begin
                     if (is_empty_now) begin
                        done = 1'b1;
                     end else begin
                        // Scan starts at the bottom entry.
                        rd_addr  = '0;
                        chk_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            res.read_value = $signed(rd_data);
            done           = 1'b1;
         end
         S_SEARCH: begin
            // rd_data holds entry chk_ff; the next entry is already requested.
            if ($signed(rd_data) == key_ff) begin
               res.found = 1'b1;
               done      = 1'b1;
            end else if (chk_ff == top_addr) begin
               done = 1'b1;
            end else begin
               chk_in = ADDR_W'(chk_ff + ADDR_W'(1));
            end
         end
         S_HOLD: begin
            if (slot_free) begin
               out_in       = hold_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The level fields always describe the stack after the operation.
      lvl_wide     = LVL_EXT_W'(level_in);
      res.level    = lvl_wide[LEVEL_OUT_W-1:0];
      res.is_empty = (level_in == '0);
      res.is_full  = (level_in == LEVEL_W'(DEPTH));

      if (done) begin
         if (slot_free) begin
            out_in       = res;
            out_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            hold_in  = res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff  <= chk_in;
      key_ff  <= key_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.read_value = out_ff.read_value;
   assign rsp_chan.status     = out_ff.status;
   assign rsp_chan.found      = out_ff.found;
   assign rsp_chan.level      = out_ff.level;
   assign rsp_chan.is_empty   = out_ff.is_empty;
   assign rsp_chan.is_full    = out_ff.is_full;

endmodule

>>> hdl/lss_checker.sv
// Port-level checker for the LIFO stack with search, and its bind.
// Depends on lss_pkg, assert_macros.svh and lifo_stack_with_search.
`include "assert_macros.svh"

module lss_checker import lss_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_read_value,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic                      rsp_found,
   input logic [LEVEL_OUT_W-1:0]    rsp_level,
   input logic                      rsp_is_empty,
   input logic                      rsp_is_full
);

   `LSS_ASSERT_IMP(a_empty_level, clock, reset, rsp_valid && rsp_is_empty,
      rsp_level == '0 && !rsp_is_full, "empty response with nonzero level or full flag")

   `LSS_ASSERT_IMP(a_found_clean, clock, reset, rsp_valid && rsp_found,
      rsp_status == STAT_OK && rsp_read_value == '0, "found flag with data or error")

   `LSS_ASSERT_IMP(a_under_empty, clock, reset, rsp_valid && rsp_status == STAT_UNDER,
      rsp_is_empty && rsp_read_value == '0 && !rsp_found, "underflow on a non-empty stack")

   `LSS_ASSERT_IMP(a_over_full, clock, reset, rsp_valid && rsp_status == STAT_OVER,
      rsp_is_full && rsp_read_value == '0 && !rsp_found, "overflow on a stack not full")

   `LSS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_read_value) && $stable(rsp_level), "stalled response changed")

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_status     (rsp_chan.status),
   .rsp_found      (rsp_chan.found),
   .rsp_level      (rsp_chan.level),
   .rsp_is_empty   (rsp_chan.is_empty),
   .rsp_is_full    (rsp_chan.is_full)
);
